// ----- src/mbt_pkg.sv -----
// ----------------------------------------------------------------------------
// mbt_pkg - shared constants and codes for the multiset bag table
// Default sizes, port widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package mbt_pkg;

  // default sizing of the table
  localparam int CAPACITY_PER_BAG_DEF = 128;
  localparam int NUM_BAGS_DEF         = 4;
  localparam int VALUE_WIDTH_DEF      = 32;

  // fixed port widths
  localparam int OP_W     = 3;
  localparam int VAL_IN_W = 32;
  localparam int BAG_IN_W = 2;
  localparam int OUT_W    = 8;
  localparam int STAT_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_COUNT  = 3'd3,
    OP_APPEND = 3'd4,
    OP_UNION  = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

endpackage

// ----- src/mbt_entry_ram.sv -----
// ----------------------------------------------------------------------------
// mbt_entry_ram - bag entry storage
// Simple dual-port RAM, one write and one registered read per cycle.
// Address is {bag, slot}.
// ----------------------------------------------------------------------------
module mbt_entry_ram #(
  parameter int CAPACITY_PER_BAG = mbt_pkg::CAPACITY_PER_BAG_DEF,
  parameter int NUM_BAGS         = mbt_pkg::NUM_BAGS_DEF,
  parameter int VALUE_WIDTH      = mbt_pkg::VALUE_WIDTH_DEF,
  localparam int SLOT_W = $clog2(CAPACITY_PER_BAG),
  localparam int BAG_W  = (NUM_BAGS > 1) ? $clog2(NUM_BAGS) : 1,
  localparam int ADDR_W = BAG_W + SLOT_W
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [ADDR_W-1:0]      waddr,
  input  logic [VALUE_WIDTH-1:0] wdata,
  input  logic [ADDR_W-1:0]      raddr,
  output logic [VALUE_WIDTH-1:0] rdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mbt_count_ram.sv -----
// ----------------------------------------------------------------------------
// mbt_count_ram - per-bag fill counts
// One write and one registered read per cycle; a valid bit per bag makes an
// unwritten count read as zero straight after reset.
// ----------------------------------------------------------------------------
module mbt_count_ram #(
  parameter int CAPACITY_PER_BAG = mbt_pkg::CAPACITY_PER_BAG_DEF,
  parameter int NUM_BAGS         = mbt_pkg::NUM_BAGS_DEF,
  localparam int CNT_W = $clog2(CAPACITY_PER_BAG + 1),
  localparam int BAG_W = (NUM_BAGS > 1) ? $clog2(NUM_BAGS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [BAG_W-1:0] waddr,
  input  logic [CNT_W-1:0] wdata,
  input  logic [BAG_W-1:0] raddr,
  output logic [CNT_W-1:0] rdata
);

  logic [CNT_W-1:0]    mem [NUM_BAGS];
  logic [NUM_BAGS-1:0] valid;
  logic [CNT_W-1:0]    rd_q;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

// ----- src/mbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbt_ctrl - operation sequencer
// Reads the fill counts, then walks, patches or copies bag entries through
// the entry RAM and, for an operation that changes a bag, writes its new fill count back.
// ----------------------------------------------------------------------------
module mbt_ctrl #(
  parameter int CAPACITY_PER_BAG = mbt_pkg::CAPACITY_PER_BAG_DEF,
  parameter int NUM_BAGS         = mbt_pkg::NUM_BAGS_DEF,
  parameter int VALUE_WIDTH      = mbt_pkg::VALUE_WIDTH_DEF,
  localparam int SLOT_W = $clog2(CAPACITY_PER_BAG),
  localparam int CNT_W  = $clog2(CAPACITY_PER_BAG + 1),
  localparam int BAG_W  = (NUM_BAGS > 1) ? $clog2(NUM_BAGS) : 1,
  localparam int ADDR_W = BAG_W + SLOT_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mbt_pkg::OP_W-1:0]      operation,
  input  logic [mbt_pkg::VAL_IN_W-1:0]  value,
  input  logic [mbt_pkg::BAG_IN_W-1:0]  bag,
  input  logic [mbt_pkg::BAG_IN_W-1:0]  first_source,
  input  logic [mbt_pkg::BAG_IN_W-1:0]  second_source,
  output logic                          busy,
  output logic                          done,
  output logic [mbt_pkg::OUT_W-1:0]     occurrence_count,
  output logic [mbt_pkg::OUT_W-1:0]     bag_size,
  output logic [mbt_pkg::STAT_W-1:0]    status,
  // fill count RAM
  output logic [BAG_W-1:0]              cnt_raddr,
  input  logic [CNT_W-1:0]              cnt_rdata,
  output logic                          cnt_we,
  output logic [BAG_W-1:0]              cnt_waddr,
  output logic [CNT_W-1:0]              cnt_wdata,
  // entry RAM
  output logic [ADDR_W-1:0]             ent_raddr,
  input  logic [VALUE_WIDTH-1:0]        ent_rdata,
  output logic                          ent_we,
  output logic [ADDR_W-1:0]             ent_waddr,
  output logic [VALUE_WIDTH-1:0]        ent_wdata
);

  import mbt_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_RD_DST = 11'b000_0000_0010,
    S_RD_S1  = 11'b000_0000_0100,
    S_RD_S2  = 11'b000_0000_1000,
    S_RD_END = 11'b000_0001_0000,
    S_DISP   = 11'b000_0010_0000,
    S_SCAN   = 11'b000_0100_0000,
    S_RM_RD  = 11'b000_1000_0000,
    S_RM_WR  = 11'b001_0000_0000,
    S_COPY   = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_t;

  // reduce a bag field modulo the number of bags
  function automatic logic [BAG_W-1:0] bag_fold(input logic [BAG_IN_W-1:0] field);
    logic [BAG_IN_W:0] v;
    v = {1'b0, field};
    for (int k = 0; k < 3; k++) begin
      if (int'(v) >= NUM_BAGS) begin
        v = v - (BAG_IN_W + 1)'(NUM_BAGS);
      end
    end
    return BAG_W'(v);
  endfunction

  state_t           state;
  op_t              op_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [BAG_W-1:0] dst_q, s1_q, s2_q;
  logic [CNT_W-1:0] n_q, m1_q, m2_q;
  logic [CNT_W-1:0] match_q;
  // walker
  logic [BAG_W-1:0]  src_q;
  logic [SLOT_W-1:0] ptr_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  off_q;
  logic              bwd_q;
  logic              pend_q;
  logic [SLOT_W-1:0] rslot_q;
  logic [SLOT_W-1:0] fslot_q;
  // second copy phase of a union
  logic              ph2_act_q;
  logic [BAG_W-1:0]  ph2_src_q;
  logic [CNT_W-1:0]  ph2_len_q;
  logic [CNT_W-1:0]  ph2_off_q;
  // result being committed
  logic              fin_wr_q;
  logic [CNT_W-1:0]  fin_size_q;
  status_t           fin_stat_q;

  logic [CNT_W:0] sum_append;
  logic [CNT_W:0] sum_union;
  logic           issue;
  logic           hit;

  assign busy = !state[0];

  assign sum_append = {1'b0, n_q} + {1'b0, m1_q};
  assign sum_union  = {1'b0, m1_q} + {1'b0, m2_q};
  assign issue      = (state == S_SCAN || state == S_COPY) && (rem_q != '0);
  assign hit        = pend_q && (ent_rdata == val_q);

  // RAM port steering
  always_comb begin
    case (state)
      S_RD_DST: cnt_raddr = dst_q;
      S_RD_S1:  cnt_raddr = s1_q;
      S_RD_S2:  cnt_raddr = s2_q;
      default:  cnt_raddr = dst_q;
    endcase
    cnt_we    = (state == S_FIN) && fin_wr_q;
    cnt_waddr = dst_q;
    cnt_wdata = fin_size_q;

    if (state == S_RM_RD) begin
      ent_raddr = {dst_q, SLOT_W'(n_q - 1'b1)};
    end else begin
      ent_raddr = {src_q, ptr_q};
    end

    ent_we    = 1'b0;
    ent_waddr = {dst_q, SLOT_W'(n_q)};
    ent_wdata = val_q;
    case (state)
      S_DISP: begin
        ent_we = (op_q == OP_INSERT) && (n_q < CNT_W'(CAPACITY_PER_BAG));
      end
      S_RM_WR: begin
        ent_we    = 1'b1;
        ent_waddr = {dst_q, fslot_q};
        ent_wdata = ent_rdata;
      end
      S_COPY: begin
        ent_we    = pend_q;
        ent_waddr = {dst_q, SLOT_W'(off_q + CNT_W'(rslot_q))};
        ent_wdata = ent_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;

      // walker read issue, shared by scan and copy
      if (issue) begin
        ptr_q   <= bwd_q ? ptr_q - 1'b1 : ptr_q + 1'b1;
        rem_q   <= rem_q - 1'b1;
        rslot_q <= ptr_q;
        pend_q  <= 1'b1;
      end else begin
        pend_q <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            op_q  <= op_t'(operation);
            val_q <= VALUE_WIDTH'(value);
            dst_q <= bag_fold(bag);
            s1_q  <= bag_fold(first_source);
            s2_q  <= bag_fold(second_source);
            state <= S_RD_DST;
          end
        end
        S_RD_DST: state <= S_RD_S1;
        S_RD_S1: begin
          n_q   <= cnt_rdata;
          state <= S_RD_S2;
        end
        S_RD_S2: begin
          m1_q  <= cnt_rdata;
          state <= S_RD_END;
        end
        S_RD_END: begin
          m2_q  <= cnt_rdata;
          state <= S_DISP;
        end
        S_DISP: begin
          match_q    <= '0;
          fin_wr_q   <= 1'b0;
          fin_stat_q <= ST_OK;
          fin_size_q <= n_q;
          ph2_act_q  <= 1'b0;
          bwd_q      <= 1'b0;
          ptr_q      <= '0;
          state      <= S_FIN;
          case (op_q)
            OP_CLEAR: begin
              fin_wr_q   <= 1'b1;
              fin_size_q <= '0;
            end
            OP_INSERT: begin
              if (n_q >= CNT_W'(CAPACITY_PER_BAG)) begin
                fin_stat_q <= ST_FULL;
              end else begin
                fin_wr_q   <= 1'b1;
                fin_size_q <= n_q + 1'b1;
              end
            end
            OP_REMOVE, OP_COUNT: begin
              src_q <= dst_q;
              rem_q <= n_q;
              state <= S_SCAN;
            end
            OP_APPEND: begin
              if (sum_append > (CNT_W + 1)'(CAPACITY_PER_BAG)) begin
                fin_stat_q <= ST_FULL;
              end else begin
                fin_wr_q   <= 1'b1;
                fin_size_q <= CNT_W'(sum_append);
                src_q      <= s1_q;
                rem_q      <= m1_q;
                off_q      <= n_q;
                state      <= S_COPY;
              end
            end
            OP_UNION: begin
              if (sum_union > (CNT_W + 1)'(CAPACITY_PER_BAG)) begin
                fin_stat_q <= ST_FULL;
              end else begin
                fin_wr_q   <= 1'b1;
                fin_size_q <= CNT_W'(sum_union);
                ph2_act_q  <= 1'b1;
                state      <= S_COPY;
                if (dst_q == s2_q && dst_q != s1_q) begin
                  // shift the old destination up first, top entry first
                  src_q     <= dst_q;
                  ptr_q     <= SLOT_W'(m2_q - 1'b1);
                  rem_q     <= m2_q;
                  off_q     <= m1_q;
                  bwd_q     <= 1'b1;
                  ph2_src_q <= s1_q;
                  ph2_len_q <= m1_q;
                  ph2_off_q <= '0;
                end else begin
                  src_q     <= s1_q;
                  rem_q     <= m1_q;
                  off_q     <= '0;
                  ph2_src_q <= s2_q;
                  ph2_len_q <= m2_q;
                  ph2_off_q <= m1_q;
                end
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (hit) begin
            if (op_q == OP_REMOVE) begin
              fslot_q <= rslot_q;
              state   <= S_RM_RD;
            end else begin
              match_q <= match_q + 1'b1;
            end
          end else if (rem_q == '0 && !pend_q) begin
            if (op_q == OP_REMOVE) begin
              fin_stat_q <= ST_NOT_FOUND;
            end
            state <= S_FIN;
          end
        end
        S_RM_RD: state <= S_RM_WR;
        S_RM_WR: begin
          fin_wr_q   <= 1'b1;
          fin_size_q <= n_q - 1'b1;
          state      <= S_FIN;
        end
        S_COPY: begin
          if (rem_q == '0 && !pend_q) begin
            if (ph2_act_q) begin
              src_q     <= ph2_src_q;
              ptr_q     <= '0;
              rem_q     <= ph2_len_q;
              off_q     <= ph2_off_q;
              bwd_q     <= 1'b0;
              ph2_act_q <= 1'b0;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          done             <= 1'b1;
          occurrence_count <= OUT_W'(match_q);
          bag_size         <= OUT_W'(fin_size_q);
          status           <= fin_stat_q;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no entry or count writes while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!ent_we && !cnt_we))
    else $error("RAM write while idle");

  // an accepted beat cannot complete in the very next cycle
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result strobe right after accept");

  // entry writes stay inside a bag
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    ent_we |-> (int'(ent_waddr[SLOT_W-1:0]) < CAPACITY_PER_BAG))
    else $error("entry write beyond bag capacity");

  // not-found only comes from a remove
  a_nf_remove: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NOT_FOUND) |-> (op_q == OP_REMOVE))
    else $error("not-found status on a non-remove operation");

  // fill count written back never exceeds capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> (int'(cnt_wdata) <= CAPACITY_PER_BAG))
    else $error("fill count above capacity");

endmodule

// ----- src/multiset_bag_table_top.sv -----
// ----------------------------------------------------------------------------
// multiset_bag_table_top - table of multiset bags
// Keeps NUM_BAGS unordered multisets with fill counts; each beat runs one
// operation (clear, insert, remove, count, append, union) on them.
// ----------------------------------------------------------------------------
//
//  channel   handshake          fields
//  -------   ----------------   ---------------------------------------------
//  command   start / busy       operation, value, bag, first_source,
//                               second_source
//  result    done (1 cycle)     occurrence_count, bag_size, status
//
//  A command beat is taken at a clock edge with start high and busy low; busy
//  stays high until the result is committed: fill-count reads, dispatch, the
//  entry walk and commit. Count and a missed remove walk the n entries of the
//  bag, append the m entries of its source; union walks both sources, the
//  second first, top entry first, when it and not the first is the destination.
//  Clear and insert walk nothing; a found remove walks up to its match slot,
//  then moves the bag's last entry into it. done is high in the first cycle with
//  busy low and the next beat can be taken at the edge that ends it. The walk
//  reads one entry a cycle through the single read port of the entry RAM.
//  rst is synchronous; it clears the sequencer and the per-bag valid bits, so
//  every bag reads empty on the first cycle after reset. No clearing pass.
//  The result is held on its ports for the single cycle that done is high;
//  the receiver has no way to stall it. A new command may arrive in that
//  same cycle.
// ----------------------------------------------------------------------------
module multiset_bag_table_top #(
  parameter int CAPACITY_PER_BAG = mbt_pkg::CAPACITY_PER_BAG_DEF,
  parameter int NUM_BAGS         = mbt_pkg::NUM_BAGS_DEF,
  parameter int VALUE_WIDTH      = mbt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mbt_pkg::OP_W-1:0]      operation,
  input  logic [mbt_pkg::VAL_IN_W-1:0]  value,
  input  logic [mbt_pkg::BAG_IN_W-1:0]  bag,
  input  logic [mbt_pkg::BAG_IN_W-1:0]  first_source,
  input  logic [mbt_pkg::BAG_IN_W-1:0]  second_source,
  output logic                          busy,
  output logic                          done,
  output logic [mbt_pkg::OUT_W-1:0]     occurrence_count,
  output logic [mbt_pkg::OUT_W-1:0]     bag_size,
  output logic [mbt_pkg::STAT_W-1:0]    status
);

  import mbt_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY_PER_BAG);
  localparam int CNT_W  = $clog2(CAPACITY_PER_BAG + 1);
  localparam int BAG_W  = (NUM_BAGS > 1) ? $clog2(NUM_BAGS) : 1;
  localparam int ADDR_W = BAG_W + SLOT_W;

  // fill count RAM hookup
  logic [BAG_W-1:0] cnt_raddr;
  logic [CNT_W-1:0] cnt_rdata;
  logic             cnt_we;
  logic [BAG_W-1:0] cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;

  // entry RAM hookup
  logic [ADDR_W-1:0]      ent_raddr;
  logic [VALUE_WIDTH-1:0] ent_rdata;
  logic                   ent_we;
  logic [ADDR_W-1:0]      ent_waddr;
  logic [VALUE_WIDTH-1:0] ent_wdata;

  // sequencer: count reads, entry walk, commit
  mbt_ctrl #(
    .CAPACITY_PER_BAG (CAPACITY_PER_BAG),
    .NUM_BAGS         (NUM_BAGS),
    .VALUE_WIDTH      (VALUE_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .operation        (operation),
    .value            (value),
    .bag              (bag),
    .first_source     (first_source),
    .second_source    (second_source),
    .busy             (busy),
    .done             (done),
    .occurrence_count (occurrence_count),
    .bag_size         (bag_size),
    .status           (status),
    .cnt_raddr        (cnt_raddr),
    .cnt_rdata        (cnt_rdata),
    .cnt_we           (cnt_we),
    .cnt_waddr        (cnt_waddr),
    .cnt_wdata        (cnt_wdata),
    .ent_raddr        (ent_raddr),
    .ent_rdata        (ent_rdata),
    .ent_we           (ent_we),
    .ent_waddr        (ent_waddr),
    .ent_wdata        (ent_wdata)
  );

  // per-bag fill counts, valid bits cleared by reset
  mbt_count_ram #(
    .CAPACITY_PER_BAG (CAPACITY_PER_BAG),
    .NUM_BAGS         (NUM_BAGS)
  ) u_count_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // bag entries, only data from slots below a fill count is ever used
  mbt_entry_ram #(
    .CAPACITY_PER_BAG (CAPACITY_PER_BAG),
    .NUM_BAGS         (NUM_BAGS),
    .VALUE_WIDTH      (VALUE_WIDTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

endmodule
